@@ sv/scld_pkg.sv @@
// Shared types, keyword tables and reply codes of the serial command line decoder.
package scld_pkg;

	// Default line buffer size in bytes.
	localparam int LINE_BUFFER_BYTES_DEF = 64;

	// Number of keywords and longest keyword.
	localparam int KW_COUNT = 7;
	localparam int KW_MAX_LEN = 5;

	// Keyword order in the match mask: PING, HELP, ident query, BL, GET, SET, BAT.
	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
		'{8'h50, 8'h49, 8'h4E, 8'h47, 8'h00},
		'{8'h48, 8'h45, 8'h4C, 8'h50, 8'h00},
		'{8'h53, 8'h43, 8'h49, 8'h4F, 8'h3F},
		'{8'h42, 8'h4C, 8'h00, 8'h00, 8'h00},
		'{8'h47, 8'h45, 8'h54, 8'h00, 8'h00},
		'{8'h53, 8'h45, 8'h54, 8'h00, 8'h00},
		'{8'h42, 8'h41, 8'h54, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd4, 3'd5, 3'd2, 3'd3, 3'd3, 3'd3};

	// First keyword codes.
	localparam logic [2:0] FK_NONE  = 3'd0;
	localparam logic [2:0] FK_PING  = 3'd1;
	localparam logic [2:0] FK_HELP  = 3'd2;
	localparam logic [2:0] FK_IDENT = 3'd3;
	localparam logic [2:0] FK_BL    = 3'd4;
	localparam logic [2:0] FK_GET   = 3'd5;
	localparam logic [2:0] FK_SET   = 3'd6;

	// Second keyword codes.
	localparam logic [1:0] SK_NONE = 2'd0;
	localparam logic [1:0] SK_BL   = 2'd1;
	localparam logic [1:0] SK_BAT  = 2'd2;

	// Mask bit positions used by the second token.
	localparam int KW_BIT_BL  = 3;
	localparam int KW_BIT_BAT = 6;

	// Character codes.
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LZ  = 8'h7A;

	// Largest accepted percent value.
	localparam logic [6:0] PCT_MAX = 7'd100;

	// Reply codes.
	typedef enum logic [3:0] {
		RC_PONG      = 4'd0,
		RC_HELP      = 4'd1,
		RC_IDENT     = 4'd2,
		RC_REPORT_BL = 4'd3,
		RC_SET_BL    = 4'd4,
		RC_REPORT_BAT = 4'd5,
		RC_RANGE_ERR = 4'd6,
		RC_GET_ERR   = 4'd7,
		RC_SET_ERR   = 4'd8,
		RC_UNKNOWN   = 4'd9,
		RC_LINE_ERR  = 4'd10
	} reply_code_t;

	// Parser state apart from the line length.
	typedef struct packed {
		logic [1:0] token_count;
		logic       inside_token;
		logic [2:0] char_position;
		logic [6:0] match_mask;
		logic [2:0] first_kw;
		logic [1:0] second_kw;
		logic [6:0] num_acc;
		logic       num_valid;
		logic [6:0] value_latched;
		logic       value_present;
		logic       value_ok;
		logic       nul_seen;
	} scld_state_t;

	// One result of a byte step.
	typedef struct packed {
		logic        valid;
		reply_code_t code;
		logic [6:0]  pct;
	} scld_result_t;

	localparam scld_state_t STATE_RESET = '{
		token_count:   2'd0,
		inside_token:  1'b0,
		char_position: 3'd0,
		match_mask:    7'h7F,
		first_kw:      FK_NONE,
		second_kw:     SK_NONE,
		num_acc:       7'd0,
		num_valid:     1'b1,
		value_latched: 7'd0,
		value_present: 1'b0,
		value_ok:      1'b0,
		nul_seen:      1'b0
	};

endpackage

@@ sv/scld_parse.sv @@
// Next-state and reply logic for one received byte of the command line decoder.
module scld_parse #(
	parameter int LINE_BUFFER_BYTES = scld_pkg::LINE_BUFFER_BYTES_DEF,
	parameter int LL_W = $clog2(LINE_BUFFER_BYTES)
) (
	input  logic [7:0]               received_byte,
	input  logic [LL_W-1:0]          line_len,
	input  scld_pkg::scld_state_t    state,
	output logic [LL_W-1:0]          line_len_next,
	output scld_pkg::scld_state_t    state_next,
	output scld_pkg::scld_result_t   result
);
	import scld_pkg::*;

	localparam logic [LL_W-1:0] LINE_LIMIT = LL_W'(LINE_BUFFER_BYTES - 1);

	// Clear the per-token fields.
	function automatic scld_state_t clear_token(input scld_state_t s);
		scld_state_t r;
		r = s;
		r.inside_token = 1'b0;
		r.char_position = 3'd0;
		r.match_mask = 7'h7F;
		r.num_acc = 7'd0;
		r.num_valid = 1'b1;
		return r;
	endfunction

	// Keyword character at a position, zero beyond the table.
	function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (pos < 3'(KW_MAX_LEN))
			c = KW_TEXT[k][pos];
		return c;
	endfunction

	// Add one token character: narrow the keyword mask and extend the number.
	function automatic scld_state_t feed_char(input scld_state_t s, input logic [7:0] ch);
		scld_state_t r;
		logic [7:0] up;
		logic [9:0] v;
		r = s;
		up = (ch >= CH_LA && ch <= CH_LZ) ? ch - 8'd32 : ch;
		r.inside_token = 1'b1;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (s.match_mask[k] && (s.char_position >= KW_LEN[k] ||
					kw_char(k, s.char_position) != up))
				r.match_mask[k] = 1'b0;
		end
		r.char_position = (s.char_position < 3'd7) ? s.char_position + 3'd1 : 3'd7;
		v = 10'(s.num_acc) * 10'd10 + 10'(ch[3:0]);
		if (ch < CH_0 || ch > CH_9) begin
			r.num_valid = 1'b0;
		end else if (s.num_valid) begin
			if (v > 10'(PCT_MAX))
				r.num_valid = 1'b0;
			else
				r.num_acc = v[6:0];
		end
		return r;
	endfunction

	// Close the current token: record keywords and the percent value.
	function automatic scld_state_t finish_token(input scld_state_t s);
		scld_state_t r;
		logic [6:0] hit;
		logic ok;
		r = s;
		for (int k = 0; k < KW_COUNT; k++)
			hit[k] = s.match_mask[k] && (KW_LEN[k] == s.char_position);
		if (s.token_count == 2'd0) begin
			r.first_kw = FK_NONE;
			for (int k = 0; k < KW_COUNT - 1; k++)
				if (hit[k])
					r.first_kw = 3'(k + 1);
		end else if (s.token_count == 2'd1) begin
			r.second_kw = hit[KW_BIT_BL] ? SK_BL : (hit[KW_BIT_BAT] ? SK_BAT : SK_NONE);
		end
		ok = s.num_valid && (s.num_acc inside {7'd0, 7'd20, 7'd40, 7'd60, 7'd80, 7'd100});
		if ((s.token_count == 2'd1 && r.first_kw == FK_BL) ||
				(s.token_count == 2'd2 && r.first_kw == FK_SET)) begin
			r.value_present = 1'b1;
			r.value_ok = ok;
			r.value_latched = ok ? s.num_acc : 7'd0;
		end
		if (s.token_count < 2'd3)
			r.token_count = s.token_count + 2'd1;
		return clear_token(r);
	endfunction

	scld_state_t fin;

	// Per-byte update and the reply at a line end.
	always_comb begin
		line_len_next = line_len;
		state_next = state;
		result.valid = 1'b0;
		result.code = RC_PONG;
		result.pct = 7'd0;
		fin = state.inside_token ? finish_token(state) : state;

		if (received_byte == CH_CR || received_byte == CH_LF) begin
			if (line_len != '0) begin
				result.valid = (fin.token_count != 2'd0);
				case (fin.first_kw)
					FK_PING:  result.code = RC_PONG;
					FK_HELP:  result.code = RC_HELP;
					FK_IDENT: result.code = RC_IDENT;
					FK_BL: begin
						if (!fin.value_present) begin
							result.code = RC_REPORT_BL;
						end else if (fin.value_ok) begin
							result.code = RC_SET_BL;
							result.pct = fin.value_latched;
						end else begin
							result.code = RC_RANGE_ERR;
						end
					end
					FK_GET: begin
						result.code = (fin.second_kw == SK_BL) ? RC_REPORT_BL :
							((fin.second_kw == SK_BAT) ? RC_REPORT_BAT : RC_GET_ERR);
					end
					FK_SET: begin
						if (fin.token_count == 2'd3 && fin.second_kw == SK_BL) begin
							if (fin.value_ok) begin
								result.code = RC_SET_BL;
								result.pct = fin.value_latched;
							end else begin
								result.code = RC_RANGE_ERR;
							end
						end else begin
							result.code = RC_SET_ERR;
						end
					end
					default: result.code = RC_UNKNOWN;
				endcase
				line_len_next = '0;
				state_next = STATE_RESET;
			end
		end else if (line_len < LINE_LIMIT) begin
			line_len_next = line_len + 1'b1;
			if (!state.nul_seen) begin
				if (received_byte == CH_NUL) begin
					state_next = fin;
					state_next.nul_seen = 1'b1;
				end else if (received_byte == CH_SP || received_byte == CH_TAB) begin
					state_next = fin;
				end else begin
					state_next = feed_char(state, received_byte);
				end
			end
		end else begin
			// Line buffer full: drop the byte and restart the line.
			line_len_next = '0;
			state_next = STATE_RESET;
			result.valid = 1'b1;
			result.code = RC_LINE_ERR;
		end
	end

endmodule

@@ sv/serial_command_line_decoder_core.sv @@
// Top level of the serial command line decoder: state registers and result register.
// A reply appears on the output in the cycle after its line-ending byte is accepted.
// Throughput: one byte per cycle; the parser state updates in a single pass per byte.
// The result register frees in the cycle it is taken, so input is held off only
// while a reply waits and out_ready is low.
// Reset (arst_n low, asynchronous) clears the line state and empties the result register.
module serial_command_line_decoder_core #(
	parameter int LINE_BUFFER_BYTES = scld_pkg::LINE_BUFFER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] received_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] reply_code,
	output logic [6:0] percent
);
	import scld_pkg::*;

	localparam int LL_W = $clog2(LINE_BUFFER_BYTES);

	logic [LL_W-1:0] line_len_q;
	logic [LL_W-1:0] line_len_next;
	scld_state_t     state_q;
	scld_state_t     state_next;
	scld_result_t    result;
	logic            out_valid_q;
	reply_code_t     reply_code_q;
	logic [6:0]      percent_q;
	logic            in_fire;

	// Input is taken whenever the result register is empty or being drained.
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire = in_valid && in_ready;

	scld_parse #(
		.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES),
		.LL_W(LL_W)
	) u_parse (
		.received_byte(received_byte),
		.line_len(line_len_q),
		.state(state_q),
		.line_len_next(line_len_next),
		.state_next(state_next),
		.result(result)
	);

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			state_q <= STATE_RESET;
		end else if (in_fire) begin
			line_len_q <= line_len_next;
			state_q <= state_next;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= result.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (in_fire && result.valid) begin
			reply_code_q <= result.code;
			percent_q <= result.pct;
		end
	end

	assign out_valid = out_valid_q;
	assign reply_code = reply_code_q;
	assign percent = percent_q;

endmodule

@@ tb/sv/serial_command_line_decoder_core_tb.sv @@
// Self-checking testbench for the serial command line decoder core.
`timescale 1ns / 100ps

module serial_command_line_decoder_core_tb;
	import scld_pkg::*;

	localparam int LINE_BYTES = LINE_BUFFER_BYTES_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int BYTE_GOAL = 1550;
	localparam int HOLD_OFF_CYCLES = 300;

	// Line parser mirror and the queue of replies it predicts.
	class reply_scoreboard;
		typedef struct {
			reply_code_t code;
			logic [6:0]  pct;
		} reply_t;

		reply_t      expected_q[$];
		int          errors;
		int          buf_limit;
		int unsigned line_len;
		logic [1:0]  tok_count;
		bit          in_tok;
		logic [2:0]  char_pos;
		logic [6:0]  kw_mask;
		logic [2:0]  first_kw;
		logic [1:0]  second_kw;
		logic [6:0]  num_acc;
		bit          num_ok;
		logic [6:0]  val_latched;
		bit          val_present;
		bit          val_ok;
		bit          nul_seen;

		function new(int line_bytes);
			buf_limit = line_bytes;
			errors = 0;
			restart_line();
		endfunction

		function void reset_token();
			in_tok = 1'b0;
			char_pos = 3'd0;
			kw_mask = 7'h7F;
			num_acc = 7'd0;
			num_ok = 1'b1;
		endfunction

		function void restart_line();
			line_len = 0;
			tok_count = 2'd0;
			first_kw = FK_NONE;
			second_kw = SK_NONE;
			val_latched = 7'd0;
			val_present = 1'b0;
			val_ok = 1'b0;
			nul_seen = 1'b0;
			reset_token();
		endfunction

		// Narrow the keyword candidates and extend the decimal value by one character.
		function void add_char(logic [7:0] ch);
			logic [7:0] up;
			int v;
			up = (ch >= CH_LA && ch <= CH_LZ) ? ch - 8'd32 : ch;
			in_tok = 1'b1;
			for (int k = 0; k < KW_COUNT; k++) begin
				if (kw_mask[k]) begin
					if (char_pos >= KW_LEN[k] || KW_TEXT[k][char_pos] != up)
						kw_mask[k] = 1'b0;
				end
			end
			if (char_pos != 3'd7)
				char_pos = char_pos + 3'd1;
			if (ch < CH_0 || ch > CH_9) begin
				num_ok = 1'b0;
			end else if (num_ok) begin
				v = int'(num_acc) * 10 + int'(ch - CH_0);
				if (v > int'(PCT_MAX))
					num_ok = 1'b0;
				else
					num_acc = 7'(v);
			end
		endfunction

		// A token ends: record which keyword it was and latch a value where one belongs.
		function void close_token();
			logic [6:0] hit;
			hit = 7'd0;
			for (int k = 0; k < KW_COUNT; k++) begin
				if (kw_mask[k] && KW_LEN[k] == char_pos)
					hit[k] = 1'b1;
			end
			if (tok_count == 2'd0) begin
				first_kw = FK_NONE;
				for (int k = 0; k < 6; k++) begin
					if (hit[k])
						first_kw = 3'(k + 1);
				end
			end else if (tok_count == 2'd1) begin
				if (hit[KW_BIT_BL])
					second_kw = SK_BL;
				else if (hit[KW_BIT_BAT])
					second_kw = SK_BAT;
				else
					second_kw = SK_NONE;
			end
			if ((tok_count == 2'd1 && first_kw == FK_BL) ||
			    (tok_count == 2'd2 && first_kw == FK_SET)) begin
				val_present = 1'b1;
				val_ok = num_ok && (num_acc % 20 == 0);
				val_latched = val_ok ? num_acc : 7'd0;
			end
			if (tok_count != 2'd3)
				tok_count = tok_count + 2'd1;
			reset_token();
		endfunction

		// One accepted byte; a line end or an overlong line may predict a reply.
		function void note_byte(logic [7:0] ch);
			reply_t r;
			r.code = RC_UNKNOWN;
			r.pct = 7'd0;
			if (ch == CH_CR || ch == CH_LF) begin
				if (line_len == 0)
					return;
				if (in_tok)
					close_token();
				if (tok_count != 2'd0) begin
					case (first_kw)
						FK_PING: r.code = RC_PONG;
						FK_HELP: r.code = RC_HELP;
						FK_IDENT: r.code = RC_IDENT;
						FK_BL: begin
							if (!val_present) begin
								r.code = RC_REPORT_BL;
							end else if (val_ok) begin
								r.code = RC_SET_BL;
								r.pct = val_latched;
							end else begin
								r.code = RC_RANGE_ERR;
							end
						end
						FK_GET: begin
							if (second_kw == SK_BL)
								r.code = RC_REPORT_BL;
							else if (second_kw == SK_BAT)
								r.code = RC_REPORT_BAT;
							else
								r.code = RC_GET_ERR;
						end
						FK_SET: begin
							if (tok_count == 2'd3 && second_kw == SK_BL) begin
								if (val_ok) begin
									r.code = RC_SET_BL;
									r.pct = val_latched;
								end else begin
									r.code = RC_RANGE_ERR;
								end
							end else begin
								r.code = RC_SET_ERR;
							end
						end
						default: r.code = RC_UNKNOWN;
					endcase
					expected_q.push_back(r);
				end
				restart_line();
			end else if (line_len < buf_limit - 1) begin
				line_len++;
				if (!nul_seen) begin
					if (ch == CH_NUL) begin
						if (in_tok)
							close_token();
						nul_seen = 1'b1;
					end else if (ch == CH_SP || ch == CH_TAB) begin
						if (in_tok)
							close_token();
					end else begin
						add_char(ch);
					end
				end
			end else begin
				restart_line();
				r.code = RC_LINE_ERR;
				expected_q.push_back(r);
			end
		endfunction

		// Compare one reply item with the oldest prediction.
		function void check_reply(logic [3:0] code, logic [6:0] pct);
			reply_t want;
			if (expected_q.size() == 0) begin
				$error("reply item with no line waiting for it: reply_code %0d, percent %0d",
					code, pct);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (code !== want.code) begin
				$error("reply_code: expected %0d, actual %0d", want.code, code);
				errors++;
			end
			if (pct !== want.pct) begin
				$error("percent: expected %0d, actual %0d", want.pct, pct);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] received_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [3:0] reply_code;
	logic [6:0] percent;

	reply_scoreboard board = new(LINE_BYTES);
	int  bytes_sent = 0;
	int  burst_left = 0;
	int  idle_cycles = 0;
	bit  hold_off_wanted = 1'b0;

	serial_command_line_decoder_core #(
		.LINE_BUFFER_BYTES(LINE_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.received_byte(received_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.reply_code(reply_code),
		.percent(percent)
	);

	// Clock.
	initial begin
		forever #2 clk = ~clk;
	end

	// Offer one byte from a falling edge and hold it until the block takes it.
	task automatic send_byte(input logic [7:0] value);
		in_valid <= 1'b1;
		received_byte <= value;
		do @(posedge clk); while (!in_ready);
		board.note_byte(value);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Bytes go out in bursts of random length with random gaps between them.
	task automatic push_byte(input logic [7:0] value);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
		burst_left--;
		send_byte(value);
	endtask

	task automatic emit_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// The ident query keyword, spelled out byte by byte.
	function automatic string ident_word();
		return $sformatf("%c%c%c%c%c", 8'h53, 8'h43, 8'h49, 8'h4F, 8'h3F);
	endfunction

	function automatic logic [7:0] blank_char();
		return ($urandom_range(0, 1) == 0) ? CH_SP : CH_TAB;
	endfunction

	function automatic logic [7:0] line_end();
		return ($urandom_range(0, 1) == 0) ? CH_CR : CH_LF;
	endfunction

	// Mostly well-formed percent values, with leading zeros, overflow and stray characters.
	function automatic string pct_text();
		string s;
		case ($urandom_range(0, 5))
			0, 1, 2: s = $sformatf("%0d", 20 * $urandom_range(0, 5));
			3: begin
				s = $sformatf("%0d", 20 * $urandom_range(0, 6));
				repeat ($urandom_range(1, 4)) s = {"0", s};
			end
			4: s = $sformatf("%0d", $urandom_range(0, 99999));
			default: s = $sformatf("%0d%c", $urandom_range(0, 120),
				8'($urandom_range(8'h21, 8'h7E)));
		endcase
		return s;
	endfunction

	// A keyword or a run of random letters, some longer than any keyword.
	function automatic string any_word();
		string s;
		case ($urandom_range(0, 7))
			0: s = "PING";
			1: s = "HELP";
			2: s = ident_word();
			3: s = "BL";
			4: s = "GET";
			5: s = "SET";
			6: s = "BAT";
			default: begin
				s = "";
				repeat ($urandom_range(1, 9))
					s = {s, $sformatf("%c", 8'h41 + $urandom_range(0, 25))};
			end
		endcase
		return s;
	endfunction

	// One random line: mostly commands with random content, some corrupted, noise or overlong.
	task automatic random_line();
		string toks[$];
		logic [7:0] line_q[$];
		string word;
		logic [7:0] ch;
		int kind;
		int spot;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			case ($urandom_range(0, 9))
				0: toks.push_back("PING");
				1: toks.push_back("HELP");
				2: toks.push_back(ident_word());
				3: toks.push_back("BL");
				4: toks = '{"BL", pct_text()};
				5: toks = '{"GET", "BL"};
				6: toks = '{"GET", "BAT"};
				7: toks = '{"GET", any_word()};
				8: toks = '{"SET", "BL", pct_text()};
				default: begin
					case ($urandom_range(0, 3))
						0: toks = '{"SET"};
						1: toks = '{"SET", "BL"};
						2: toks = '{"SET", "BAT", pct_text()};
						default: toks = '{"SET", any_word(), pct_text()};
					endcase
				end
			endcase
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) toks.push_back(any_word());
			repeat ($urandom_range(0, 2)) line_q.push_back(blank_char());
			foreach (toks[i]) begin
				if (i > 0)
					repeat ($urandom_range(1, 3)) line_q.push_back(blank_char());
				word = toks[i];
				for (int j = 0; j < word.len(); j++) begin
					ch = word[j];
					if (ch >= 8'h41 && ch <= 8'h5A && $urandom_range(0, 1) == 1)
						ch = ch + 8'd32;
					line_q.push_back(ch);
				end
			end
			repeat ($urandom_range(0, 2)) line_q.push_back(blank_char());
			// Break the line at one spot: a zero byte or any other byte.
			if (kind >= 70) begin
				spot = $urandom_range(0, line_q.size() - 1);
				if ($urandom_range(0, 1) == 0)
					line_q[spot] = CH_NUL;
				else
					line_q[spot] = 8'($urandom_range(0, 255));
			end
		end else if (kind < 95) begin
			repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(58, 72)) begin
				if ($urandom_range(0, 4) == 0)
					line_q.push_back(blank_char());
				else
					line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
			end
		end
		line_q.push_back(line_end());
		if ($urandom_range(0, 9) == 0)
			line_q.push_back(line_end());
		foreach (line_q[i])
			push_byte(line_q[i]);
	endtask

	// Receiver: stretches of full speed, random stalls and heavy stalls, plus one long hold-off.
	initial begin : receiver
		int mode;
		bit held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_wanted && !held) begin
				held = 1'b1;
				repeat (HOLD_OFF_CYCLES) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end else begin
				mode = $urandom_range(0, 2);
				repeat ($urandom_range(10, 120)) begin
					@(negedge clk);
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= ($urandom_range(0, 1) == 1);
						default: out_ready <= ($urandom_range(0, 4) == 0);
					endcase
				end
			end
		end
	end

	// Check every reply item the block hands over.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_reply(reply_code, percent);
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	// Reset, directed lines, random lines, then drain.
	initial begin : stimulus
		string filler;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Every command, both cases, value limits and malformed values.
		emit_text("PING\r");
		emit_text("help\n");
		emit_text({ident_word(), "\r"});
		emit_text("BL\r");
		emit_text("BL 0\r");
		emit_text("bl 100\n");
		emit_text("Bl 40 extra tokens here\r");
		emit_text("BL 30\r");
		emit_text("BL 120\r");
		emit_text("BL 4x\r");
		emit_text("BL 00080\r");
		emit_text("GET BL\r");
		emit_text("get bat\n");
		emit_text("GET foo\r");
		emit_text("GET\r");
		emit_text("SET BL 60\r");
		emit_text("set bl 101\r");
		emit_text("SET BAT 20\r");
		emit_text("SET BL\r");
		emit_text("SET\r");
		emit_text("PINGX\r");
		// Empty and blank-only lines give nothing.
		emit_text("\r");
		emit_text(" \t \n");
		emit_text("\tPING\t\r");
		// A zero byte ends the token and hides the rest of the line.
		emit_text("PI");
		push_byte(CH_NUL);
		emit_text("NG\r");
		emit_text("BL");
		push_byte(CH_NUL);
		emit_text(" 40\r");
		// High bytes are plain token characters.
		push_byte(8'hFF);
		push_byte(8'h80);
		push_byte(8'h7F);
		emit_text("\r");
		// The longest line that fits, then one character more than that.
		filler = "PING";
		repeat (LINE_BYTES - 5) filler = {filler, " "};
		emit_text({filler, "\r"});
		filler = "";
		repeat (LINE_BYTES) filler = {filler, "Z"};
		emit_text({filler, "\r"});

		hold_off_wanted = 1'b1;
		while (bytes_sent < BYTE_GOAL)
			random_line();
		in_valid <= 1'b0;

		while (board.pending() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ serial_command_line_decoder_core.f @@
sv/scld_pkg.sv
sv/scld_parse.sv
sv/serial_command_line_decoder_core.sv
tb/sv/serial_command_line_decoder_core_tb.sv
